### hdl/jsc_pkg.sv
// Shared types, constants and conversion helpers for the JIS / Shift-JIS converter.
package jsc_pkg;

  typedef enum logic [2:0] {
    OP_JIS_TO_IDX  = 3'd0,
    OP_IDX_TO_JIS  = 3'd1,
    OP_SJ_TO_IDX   = 3'd2,
    OP_IDX_TO_SJ   = 3'd3,
    OP_SJ_TO_JIS   = 3'd4,
    OP_JIS_TO_SJ   = 3'd5,
    OP_IDX_TO_FONT = 3'd6,
    OP_LOAD_COUNT  = 3'd7
  } op_t;

  localparam logic [15:0] SubstReset  = 16'd71;
  localparam logic [15:0] IdxJisMax   = 16'd8835;
  localparam logic [15:0] SjFallback  = 16'h8188;
  localparam logic [8:0]  SjRowMax    = 9'd59;
  localparam logic [8:0]  SjLowRowMax = 9'd30;

  localparam logic [7:0] JisByteMin  = 8'h21;
  localparam logic [7:0] JisLowMax   = 8'h7E;
  localparam logic [7:0] JisHighMax  = 8'h73;
  localparam logic [7:0] SjLead1Min  = 8'h81;
  localparam logic [7:0] SjLead1Max  = 8'h9F;
  localparam logic [7:0] SjLead2Min  = 8'hE0;
  localparam logic [7:0] SjLead2Max  = 8'hFC;
  localparam logic [7:0] SjLead2Base = 8'hC1;
  localparam logic [7:0] SjTrailMin  = 8'h40;
  localparam logic [7:0] SjTrailMax  = 8'hFC;
  localparam logic [7:0] SjTrailGap  = 8'h7F;
  localparam logic [7:0] RowLen      = 8'd94;

  // x / 94 for 16-bit x: exact reciprocal multiply, 89241 = ceil(2^23 / 94)
  localparam logic [16:0] Div94Mul   = 17'd89241;
  localparam int          Div94Shift = 23;

  typedef struct packed {
    logic [9:0] q;
    logic [6:0] r;
  } div94_t;

  // Substitute index with its conversions worked out at write time
  typedef struct packed {
    logic [15:0] idx;
    logic [15:0] jis;
    logic [15:0] sj;
    logic        big;
    logic        sj_bad;
  } subst_t;

  typedef struct packed {
    logic [15:0] code;
    logic [1:0]  err_inc;
  } conv_t;

  function automatic div94_t div94(input logic [15:0] x);
    logic [32:0] prod;
    logic [15:0] back;
    div94_t      d;
    prod = 33'(x) * 33'(Div94Mul);
    d.q  = prod[Div94Shift +: 10];
    back = 16'(d.q) * 16'(RowLen);
    d.r  = 7'(x - back);
    return d;
  endfunction

  // Row/column pair to JIS code; high byte wraps like a 16-bit mask
  function automatic logic [15:0] jis_of_cell(input logic [9:0] q, input logic [6:0] r);
    return {8'(q) + JisByteMin, {1'b0, r} + JisByteMin};
  endfunction

  // Quotient/remainder by 188 to Shift-JIS, skipping leads 0xA0..0xDF and trail 0x7F
  function automatic logic [15:0] sj_code(input logic [8:0] q, input logic [7:0] r);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = (q <= SjLowRowMax) ? 8'(q) + SjLead1Min : 8'(q) + SjLead2Base;
    lo = r + SjTrailMin;
    if (lo >= SjTrailGap) lo = lo + 8'd1;
    return {hi, lo};
  endfunction

  function automatic subst_t subst_of(input logic [15:0] x);
    div94_t     d;
    logic [8:0] q188;
    logic [7:0] r188;
    subst_t     s;
    d      = div94(x);
    q188   = d.q[9:1];
    r188   = d.q[0] ? {1'b0, d.r} + RowLen : {1'b0, d.r};
    s.idx  = x;
    s.jis  = jis_of_cell(d.q, d.r);
    s.big  = x > IdxJisMax;
    s.sj_bad = q188 > SjRowMax;
    s.sj   = s.sj_bad ? SjFallback : sj_code(q188, r188);
    return s;
  endfunction

endpackage

### hdl/jis_shift_jis_code_converter_core.sv
// Top level of the JIS / Shift-JIS code converter: handshake, error counter, registers.
//
// Input channel: in_valid / in_stall carry in_op and in_value_in. A transaction
// completes on a rising edge with in_valid high and in_stall low.
// Result channel: out_valid / out_stall carry out_converted, out_range_error and
// out_error_total, one result per input transaction, in order.
// Configuration: cfg_wr_en writes cfg_wr_data into the substitute index (reset 71);
// its JIS and Shift-JIS forms are computed at the write, so write only while idle.
// An accepted item is held in the input register, passes through one pass of
// conversion logic and is captured in the result register. Throughput is one
// item per cycle while the result is not stalled.
// A stalled result holds in the output register while the input register still
// takes one more item; in_stall rises only while both registers are full.
// Reset (rst_n low, synchronous) empties both registers, clears the error
// counter and restores the substitute index to 71.
module jis_shift_jis_code_converter_core
  import jsc_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [15:0] in_value_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_converted,
  output logic        out_range_error,
  output logic [15:0] out_error_total,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  subst_t sub;
  conv_t  res;

  logic                   s1_valid_r, s1_valid_nxt;
  op_t                    op_r, op_nxt;
  logic [15:0]            val_r, val_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [15:0]            conv_r, conv_nxt;
  logic                   rerr_r, rerr_nxt;
  logic [15:0]            total_r, total_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   advance;
  logic                   move;
  logic                   accept;

  jsc_subst u_subst (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sub         (sub)
  );

  jsc_conv u_conv (
    .op    (op_r),
    .value (val_r),
    .sub   (sub),
    .res   (res)
  );

  always_comb begin
    advance  = !out_valid_r || !out_stall;
    move     = s1_valid_r && advance;
    in_stall = s1_valid_r && !advance;
    accept   = in_valid && !in_stall;

    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (move) begin
      s1_valid_nxt = 1'b0;
    end
    op_nxt  = accept ? op_t'(in_op) : op_r;
    val_nxt = accept ? in_value_in : val_r;

    // counter advances, or loads the value on a count-load op, when the item leaves for the result register
    count_nxt = count_r;
    if (move) begin
      if (op_r == OP_LOAD_COUNT) begin
        count_nxt = COUNT_WIDTH'(val_r);
      end else begin
        count_nxt = count_r + COUNT_WIDTH'(res.err_inc);
      end
    end

    out_valid_nxt = out_valid_r;
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    conv_nxt  = conv_r;
    rerr_nxt  = rerr_r;
    total_nxt = total_r;
    if (move) begin
      conv_nxt  = (op_r == OP_LOAD_COUNT) ? 16'(count_r) : res.code;
      rerr_nxt  = res.err_inc != 2'd0;
      total_nxt = 16'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    val_r   <= val_nxt;
    conv_r  <= conv_nxt;
    rerr_r  <= rerr_nxt;
    total_r <= total_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_converted   = conv_r;
  assign out_range_error = rerr_r;
  assign out_error_total = total_r;

endmodule

### hdl/jsc_subst.sv
// Substitute index register with its precomputed JIS and Shift-JIS forms.
module jsc_subst
  import jsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output subst_t      sub
);

  subst_t sub_r;
  subst_t sub_nxt;

  always_comb begin
    sub_nxt = sub_r;
    if (cfg_wr_en) sub_nxt = subst_of(cfg_wr_data);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= subst_of(SubstReset);
    end else begin
      sub_r <= sub_nxt;
    end
  end

  assign sub = sub_r;

endmodule

### hdl/jsc_conv.sv
// Single-pass code conversion for one item: all ops but the count load.
module jsc_conv
  import jsc_pkg::*;
(
  input  op_t         op,
  input  logic [15:0] value,
  input  subst_t      sub,
  output conv_t       res
);

  logic [7:0]  hi;
  logic [7:0]  lo;
  logic        jis_ok;
  logic [6:0]  jrow;
  logic [6:0]  jcol;
  logic [12:0] jis_cell;
  logic [8:0]  jq188;
  logic [7:0]  jr188;
  logic        lead_ok;
  logic        sj_ok;
  logic [5:0]  sa;
  logic [7:0]  sb;
  logic [13:0] sj_cell;
  logic        sj_fits;
  logic        sb_hi;
  logic [9:0]  sq;
  logic [6:0]  sr;
  div94_t      vd;
  logic [8:0]  vq188;
  logic [7:0]  vr188;
  logic        font_ok;
  logic [15:0] font_code;

  always_comb begin
    hi = value[15:8];
    lo = value[7:0];

    // JIS decode: row and column from zero
    jis_ok   = (lo >= JisByteMin) && (lo <= JisLowMax) &&
               (hi >= JisByteMin) && (hi <= JisHighMax);
    jrow     = 7'(hi - JisByteMin);
    jcol     = 7'(lo - JisByteMin);
    jis_cell = 13'(13'(jrow) * 13'(RowLen)) + 13'(jcol);
    // a valid JIS cell always fits a Shift-JIS lead: pair rows directly
    jq188    = 9'(jrow[6:1]);
    jr188    = {1'b0, jcol} + (jrow[0] ? RowLen : 8'd0);

    // Shift-JIS decode
    lead_ok = ((hi >= SjLead1Min) && (hi <= SjLead1Max)) ||
              ((hi >= SjLead2Min) && (hi <= SjLead2Max));
    sj_ok   = lead_ok && (lo >= SjTrailMin) && (lo <= SjTrailMax) && (lo != SjTrailGap);
    sa      = (hi >= SjLead2Min) ? 6'(hi - SjLead2Base) : 6'(hi - SjLead1Min);
    sb      = (lo > SjTrailGap) ? lo - SjTrailMin - 8'd1 : lo - SjTrailMin;
    sj_cell = 14'(14'(sa) * 14'd188) + 14'(sb);
    sj_fits = sj_cell <= 14'(IdxJisMax);
    // split the 188-wide pair back into two 94-wide rows
    sb_hi   = sb >= RowLen;
    sq      = 10'({sa, 1'b0}) + 10'(sb_hi);
    sr      = sb_hi ? 7'(sb - RowLen) : 7'(sb);

    // index operand split by 94 and 188
    vd    = div94(value);
    vq188 = vd.q[9:1];
    vr188 = vd.q[0] ? {1'b0, vd.r} + RowLen : {1'b0, vd.r};

    // font file moves the mapped ranges down, closing most gaps between them; other indices give the substitute
    font_ok   = 1'b1;
    font_code = value;
    case (value) inside
      [16'd0:16'd107]:     font_code = value;
      [16'd203:16'd212]:   font_code = value - 16'd56;
      [16'd220:16'd245]:   font_code = value - 16'd63;
      [16'd252:16'd277]:   font_code = value - 16'd69;
      [16'd282:16'd364]:   font_code = value - 16'd73;
      [16'd376:16'd461]:   font_code = value - 16'd84;
      [16'd470:16'd493]:   font_code = value - 16'd92;
      [16'd502:16'd525]:   font_code = value - 16'd100;
      [16'd564:16'd596]:   font_code = value - 16'd138;
      [16'd612:16'd644]:   font_code = value - 16'd153;
      [16'd1410:16'd4374]: font_code = value - 16'd886;
      [16'd4418:16'd7805]: font_code = value;
      default: begin
        font_ok   = 1'b0;
        font_code = sub.idx;
      end
    endcase

    res.code    = '0;
    res.err_inc = 2'd0;
    case (op)
      OP_JIS_TO_IDX: begin
        res.code    = jis_ok ? 16'(jis_cell) : sub.idx;
        res.err_inc = {1'b0, !jis_ok};
      end
      OP_IDX_TO_JIS: begin
        res.code    = (value <= IdxJisMax) ? jis_of_cell(vd.q, vd.r) : sub.jis;
        res.err_inc = {1'b0, value > IdxJisMax};
      end
      OP_SJ_TO_IDX: begin
        res.code    = sj_ok ? 16'(sj_cell) : sub.idx;
        res.err_inc = {1'b0, !sj_ok};
      end
      OP_IDX_TO_SJ: begin
        res.code    = (vq188 <= SjRowMax) ? sj_code(vq188, vr188) : sub.sj;
        res.err_inc = {1'b0, vq188 > SjRowMax};
      end
      OP_SJ_TO_JIS: begin
        if (sj_ok && sj_fits) begin
          res.code = jis_of_cell(sq, sr);
        end else begin
          res.code = sub.jis;
        end
        if (sj_ok) begin
          res.err_inc = {1'b0, !sj_fits};
        end else begin
          res.err_inc = 2'd1 + 2'(sub.big);
        end
      end
      OP_JIS_TO_SJ: begin
        if (jis_ok) begin
          res.code    = sj_code(jq188, jr188);
          res.err_inc = 2'd0;
        end else begin
          res.code    = sub.sj;
          res.err_inc = 2'd1 + 2'(sub.sj_bad);
        end
      end
      OP_IDX_TO_FONT: begin
        res.code    = font_code;
        res.err_inc = {1'b0, !font_ok};
      end
      default: begin
        res.code    = '0;
        res.err_inc = 2'd0;
      end
    endcase
  end

endmodule

### hdl/jsc_checker.sv
// Port-level checks for the converter top level, bound to it.
module jsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_converted,
  input logic        out_range_error,
  input logic [15:0] out_error_total
);

  logic        seen_r, seen_nxt;
  logic [15:0] last_total_r, last_total_nxt;
  logic        out_acc;

  always_comb begin
    out_acc        = out_valid && !out_stall;
    seen_nxt       = seen_r || out_acc;
    last_total_nxt = out_acc ? out_error_total : last_total_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_total_r <= last_total_nxt;
  end

  // reset leaves both sides empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("outputs not idle after reset");

  // input backs up only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a stalled result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_converted) &&
      $stable(out_range_error) && $stable(out_error_total))
    else $error("stalled result changed");

  // a flagged result always moves the error total
  a_err_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_range_error && seen_r |-> out_error_total != last_total_r)
    else $error("range error did not advance the count");

endmodule

bind jis_shift_jis_code_converter_core jsc_checker u_jsc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_converted   (out_converted),
  .out_range_error (out_range_error),
  .out_error_total (out_error_total)
);
